### rtl/core/mbft_pkg.sv
// Shared types and constants for the two-line serial frame transmitter.
package mbft_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned STEP_W = 4;
    localparam logic [STEP_W-1:0] START_STEP_LAST = STEP_W'(10);
    localparam logic [STEP_W-1:0] BYTE_STEP_LAST  = STEP_W'(15);
    localparam logic [STEP_W-1:0] END_STEP_LAST   = STEP_W'(6);

    // One byte of work handed from the front to the back.
    typedef struct packed {
        logic       start;   // open the frame with the start pattern first
        logic [7:0] data;    // payload byte
        logic       last;    // close the frame after this byte
        logic [7:0] check;   // check byte to send when last is set
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_BYTE,
        PH_CHECK,
        PH_END
    } t_phase;

    // Pin snapshot, packed as it goes onto the output bus.
    typedef struct packed {
        logic line_b;
        logic line_a;
        logic drive_enable;
    } t_snap;

endpackage

### rtl/core/mbft_front.sv
// Front end: accepts frame bytes, tracks frame state and the running check byte.
module mbft_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tvalid,
    output logic          o_tready,
    input  logic [7:0]    i_tdata,
    input  logic          i_tlast,
    input  logic          i_q_full,
    output logic          o_push,
    output mbft_pkg::t_cmd o_cmd
);
    import mbft_pkg::*;

    logic       r_in_frame;
    logic [7:0] r_check;
    logic       n_in_frame;
    logic [7:0] n_check;
    logic [7:0] w_check;

    assign o_tready = !i_q_full;
    assign o_push   = i_tvalid && !i_q_full;

    // A closed frame restarts the check from zero.
    assign w_check = (r_in_frame ? r_check : 8'h00) ^ i_tdata;

    always_comb begin
        o_cmd.start = !r_in_frame;
        o_cmd.data  = i_tdata;
        o_cmd.last  = i_tlast;
        o_cmd.check = w_check;
        n_in_frame  = r_in_frame;
        n_check     = r_check;
        if (o_push) begin
            n_in_frame = !i_tlast;
            n_check    = i_tlast ? 8'h00 : w_check;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_check    <= 8'h00;
        end else begin
            r_in_frame <= n_in_frame;
            r_check    <= n_check;
        end
    end

endmodule

### rtl/core/mbft_queue.sv
// Short command queue between the front end and the bit sequencer.
module mbft_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mbft_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output mbft_pkg::t_cmd o_cmd
);
    import mbft_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   w_do_pop;

    assign o_full   = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_cmd    = r_mem[r_rd_ptr];
    assign w_do_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            case ({i_push, w_do_pop})
                2'b10:   r_count <= r_count + QUEUE_CNT_W'(1);
                2'b01:   r_count <= r_count - QUEUE_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/mbft_back.sv
// Back end: steps through start, data, check and end snapshots into an output register.
module mbft_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  mbft_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_tvalid,
    input  logic           i_tready,
    output mbft_pkg::t_snap o_snap,
    output logic           o_tlast
);
    import mbft_pkg::*;

    t_phase            r_phase;
    t_phase            n_phase;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_out_valid;
    t_snap             r_out_snap;
    logic              r_out_last;

    t_phase            w_phase;
    logic              w_advance;
    logic              w_emit;
    t_snap             w_snap;
    logic              w_item_end;
    logic [7:0]        w_byte;
    logic              w_bit;

    assign w_advance = !r_out_valid || i_tready;
    // From idle the head command starts at once, so bytes follow without a gap.
    assign w_phase   = (r_phase != PH_IDLE) ? r_phase
                     : (i_cmd.start ? PH_START : PH_BYTE);
    assign w_emit    = w_advance && !(r_phase == PH_IDLE && i_q_empty);
    assign w_byte    = (w_phase == PH_CHECK) ? i_cmd.check : i_cmd.data;
    assign w_bit     = w_byte[3'd7 - r_step[3:1]];

    always_comb begin
        w_snap     = '{line_b: 1'b1, line_a: 1'b1, drive_enable: 1'b1};
        w_item_end = 1'b0;
        n_phase    = r_phase;
        n_step     = r_step;
        case (w_phase)
            PH_START: begin
                if (r_step == '0 || r_step == START_STEP_LAST) begin
                    w_snap.line_a = 1'b1;
                    w_snap.line_b = 1'b1;
                end else begin
                    w_snap.line_a = 1'b0;
                    w_snap.line_b = r_step[0];
                end
                if (r_step == START_STEP_LAST) begin
                    n_phase = PH_BYTE;
                    n_step  = '0;
                end else begin
                    n_phase = PH_START;
                    n_step  = r_step + STEP_W'(1);
                end
            end
            PH_BYTE, PH_CHECK: begin
                // Lines swap clock and data roles on every bit.
                if (!r_step[1]) begin
                    w_snap.line_a = !r_step[0];
                    w_snap.line_b = w_bit;
                end else begin
                    w_snap.line_a = w_bit;
                    w_snap.line_b = !r_step[0];
                end
                if (r_step == BYTE_STEP_LAST) begin
                    n_step = '0;
                    if (w_phase == PH_BYTE && i_cmd.last) begin
                        n_phase = PH_CHECK;
                    end else if (w_phase == PH_BYTE) begin
                        n_phase    = PH_IDLE;
                        w_item_end = 1'b1;
                    end else begin
                        n_phase = PH_END;
                    end
                end else begin
                    n_phase = w_phase;
                    n_step  = r_step + STEP_W'(1);
                end
            end
            PH_END: begin
                if (r_step == END_STEP_LAST) begin
                    // Release the lines, reporting both lines as high.
                    w_snap.drive_enable = 1'b0;
                    w_snap.line_a       = 1'b1;
                    w_snap.line_b       = 1'b1;
                    n_phase             = PH_IDLE;
                    n_step              = '0;
                    w_item_end          = 1'b1;
                end else begin
                    w_snap.line_a = (r_step == '0) || r_step[0];
                    w_snap.line_b = (r_step == '0);
                    n_phase       = PH_END;
                    n_step        = r_step + STEP_W'(1);
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_step  = '0;
            end
        endcase
        if (!w_emit) begin
            n_phase    = r_phase;
            n_step     = r_step;
            w_item_end = 1'b0;
        end
    end

    assign o_pop    = w_item_end;
    assign o_tvalid = r_out_valid;
    assign o_snap   = r_out_snap;
    assign o_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
            if (w_advance) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_snap <= w_snap;
            r_out_last <= w_item_end;
        end
    end

endmodule

### rtl/core/maple_bus_frame_transmitter_core.sv
// Top level of the two-line serial frame transmitter.
//
// Slave channel: one frame byte per transfer on i_s_tdata, i_s_tlast marking
// the final payload byte of a frame. Master channel: one pin snapshot per
// transfer (drive enable, line A, line B); an external pacer takes one
// snapshot per time unit. o_m_tlast marks the final snapshot of each byte.
// A mid-frame byte gives 16 snapshots; the first byte of a frame adds 11 for
// the start pattern; the closing byte adds 16 for the check byte and 7 for
// the end pattern and release, so up to 50 snapshots come from one byte.
// The bit sequencer emits one snapshot a cycle while the receiver accepts
// and the queue holds a byte. An accepted byte is written into the queue,
// and its first snapshot then passes through the output register.
// A two-entry queue lets the next bytes be taken while snapshots drain.
// When the receiver stalls, the output register holds its snapshot and the
// sequencer waits; the slave side stalls once the queue is full.
// Synchronous reset closes any open frame, clears the check byte, empties
// the queue and drops o_m_tvalid.
module maple_bus_frame_transmitter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] byte_value
    input  logic       i_s_tlast,   // last_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [0] drive_enable, [1] line_a, [2] line_b, rest zero
    output logic       o_m_tlast    // last_step
);
    import mbft_pkg::*;

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    t_cmd  w_in_cmd;
    t_cmd  w_head_cmd;
    t_snap w_snap;

    mbft_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_tdata  (i_s_tdata),
        .i_tlast  (i_s_tlast),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cmd    (w_in_cmd)
    );

    mbft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_in_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_head_cmd)
    );

    mbft_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_cmd     (w_head_cmd),
        .o_pop     (w_pop),
        .o_tvalid  (o_m_tvalid),
        .i_tready  (i_m_tready),
        .o_snap    (w_snap),
        .o_tlast   (o_m_tlast)
    );

    assign o_m_tdata = {5'b00000, w_snap};

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two-line serial frame transmitter core.
module tb;

    typedef struct packed {
        logic drv;
        logic a;
        logic b;
        logic fin;
    } t_pin;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic [7:0] n_pins;
    } t_row;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle;

    localparam int N_DIR          = 15;
    localparam int RAND_PER_PHASE = 52;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 20;

    // byte, last flag, snapshot count for that byte
    localparam t_row DIR_ROWS [N_DIR] = '{
        '{8'h00, 1'b1, 8'd50},  // one-byte frame straight after reset
        '{8'hFF, 1'b1, 8'd50},
        '{8'hA5, 1'b0, 8'd27},  // frame opening
        '{8'h5A, 1'b0, 8'd16},
        '{8'hFF, 1'b0, 8'd16},
        '{8'h00, 1'b0, 8'd16},
        '{8'h81, 1'b1, 8'd39},  // frame closing
        '{8'h80, 1'b0, 8'd27},
        '{8'h01, 1'b0, 8'd16},
        '{8'h7E, 1'b0, 8'd16},
        '{8'hC3, 1'b0, 8'd16},
        '{8'h3C, 1'b1, 8'd39},
        '{8'h55, 1'b0, 8'd27},
        '{8'hAA, 1'b1, 8'd39},
        '{8'h00, 1'b1, 8'd50}
    };

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic [7:0] i_s_tdata  = 8'h00;
    logic       i_s_tlast  = 1'b0;
    logic       i_m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;

    t_pin       pin_q[$];
    logic       frame_open = 1'b0;
    logic [7:0] frame_xor  = 8'h00;
    int         err_cnt    = 0;
    t_idle      idle_mode  = IDLE_NONE;
    bit         hold_req   = 1'b0;

    maple_bus_frame_transmitter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [7:0] byte_value
        .i_s_tlast  (i_s_tlast),   // last_byte
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [0] drive_enable, [1] line_a, [2] line_b, rest zero
        .o_m_tlast  (o_m_tlast)    // last_step
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int send_idle_pct();
        case (idle_mode)
            IDLE_SEND: return 86;
            IDLE_BOTH: return 30;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (idle_mode)
            IDLE_RECV: return 86;
            IDLE_BOTH: return 30;
            default:   return 0;
        endcase
    endfunction

    function automatic void add_pin(logic drv, logic a, logic b);
        pin_q.push_back('{drv, a, b, 1'b0});
    endfunction

    // Even bit positions clock line A and carry data on B; odd ones swap roles.
    function automatic void add_byte(logic [7:0] v);
        for (int i = 7; i >= 0; i--) begin
            if (((7 - i) & 1) == 0) begin
                add_pin(1'b1, 1'b1, v[i]);
                add_pin(1'b1, 1'b0, v[i]);
            end else begin
                add_pin(1'b1, v[i], 1'b1);
                add_pin(1'b1, v[i], 1'b0);
            end
        end
    endfunction

    function automatic void predict_pins(logic [7:0] v, logic l);
        if (!frame_open) begin
            add_pin(1'b1, 1'b1, 1'b1);
            for (int k = 0; k < 4; k++) begin
                add_pin(1'b1, 1'b0, 1'b1);
                add_pin(1'b1, 1'b0, 1'b0);
            end
            add_pin(1'b1, 1'b0, 1'b1);
            add_pin(1'b1, 1'b1, 1'b1);
            frame_open = 1'b1;
            frame_xor  = 8'h00;
        end
        add_byte(v);
        frame_xor ^= v;
        if (l) begin
            add_byte(frame_xor);
            add_pin(1'b1, 1'b1, 1'b1);
            for (int k = 0; k < 2; k++) begin
                add_pin(1'b1, 1'b1, 1'b0);
                add_pin(1'b1, 1'b0, 1'b0);
            end
            add_pin(1'b1, 1'b1, 1'b0);
            // release: lines read back high
            add_pin(1'b0, 1'b1, 1'b1);
            frame_open = 1'b0;
            frame_xor  = 8'h00;
        end
        pin_q[pin_q.size() - 1].fin = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic send_byte(input logic [7:0] v, input logic l, output int n_new);
        int n_prev;
        while ($urandom_range(99) < send_idle_pct()) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        i_s_tlast  <= l;
        do @(posedge i_clk); while (!o_s_tready);
        n_prev = pin_q.size();
        predict_pins(v, l);
        n_new = pin_q.size() - n_prev;
    endtask

    task automatic pause_until_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pin_q.size() != 0);
    endtask

    task automatic set_mode(input t_idle m);
        @(negedge i_clk);
        idle_mode = m;
        @(posedge i_clk);
    endtask

    // Snapshot side: check each transfer, then choose tready for the next edge.
    initial begin : snapshot_side
        int   hold_left;
        t_pin want;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (pin_q.size() == 0) begin
                    $error("snapshot with nothing expected: tdata=%h tlast=%b",
                           o_m_tdata, o_m_tlast);
                    err_cnt++;
                end else begin
                    want = pin_q.pop_front();
                    check_field("drive_enable", 8'(want.drv), 8'(o_m_tdata[0]));
                    check_field("line_a", 8'(want.a), 8'(o_m_tdata[1]));
                    check_field("line_b", 8'(want.b), 8'(o_m_tdata[2]));
                    check_field("last_step", 8'(want.fin), 8'(o_m_tlast));
                    check_field("tdata padding", 8'h00, 8'(o_m_tdata[7:3]));
                end
            end
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct());
            end
        end
    end

    initial begin : byte_side
        int         n_new;
        int         sent;
        int         len;
        logic [7:0] v;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            send_byte(DIR_ROWS[r].data, DIR_ROWS[r].fin, n_new);
            if (n_new != int'(DIR_ROWS[r].n_pins)) begin
                $error("snapshot count of row %0d: expected %0d, got %0d",
                       r, DIR_ROWS[r].n_pins, n_new);
                err_cnt++;
            end
        end
        pause_until_drained();

        // hold the snapshot side off while bytes keep coming, so the queue fills
        @(negedge i_clk);
        hold_req = 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            set_mode(t_idle'(ph));
            sent = 0;
            while (sent < RAND_PER_PHASE) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(5, 1);
                for (int b = 0; b < len; b++) begin
                    v = pick_byte();
                    send_byte(v, b == len - 1, n_new);
                    sent++;
                end
            end
            pause_until_drained();
        end

        set_mode(IDLE_NONE);
        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### maple_bus_frame_transmitter_core.f
rtl/core/mbft_pkg.sv
rtl/core/mbft_front.sv
rtl/core/mbft_queue.sv
rtl/core/mbft_back.sv
rtl/core/maple_bus_frame_transmitter_core.sv
tb/sv/tb.sv
